>>> hw/rtl/swrv_pkg.sv
package swrv_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 16;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] value;
  } swrv_in_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [15:0] top_value;
  } swrv_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       push_wr;
    logic       cnt_dec;
    logic       idx_from_top;
    logic       idx_dec;
    logic       idx_inc;
    logic       rd_idx;
    logic       rd_idx_next;
    logic       rd_top;
    logic       shift_wr;
    logic       top_cap;
    logic       set_status;
    logic [1:0] status;
  } swrv_dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic match;
    logic idx_zero;
    logic shift_more;
  } swrv_dp_stat_t;

endpackage

>>> hw/rtl/stack_with_remove_by_value.sv
// Stack of window numbers with push, pop and remove-by-value.
// Input channel: a command (push, pop, remove) and a value in in_item is
// taken on a rising edge with start high and busy low. busy stays high
// until the result has been shown.
// Result channel: out_item carries status, entry count, empty flag and the
// top value after the command; out_valid is high for exactly one cycle and
// the receiver cannot stall it, so the result must be taken then.
// Steps per command after the accepting edge: push, failed pop, remove on
// an empty stack and an unused code go from the execute state straight to
// the result; pop then reads the new top entry; remove scans entries from
// the top, on a match moves each entry above it down by one and then reads
// the new top; the top read is skipped when the stack is left empty, and an
// unmatched remove scans every held entry.
// The entry store has one registered read port, so every scanned or moved
// entry takes a read step and then a compare or write step.
// busy drops in the cycle after the result strobe, and a new command is
// taken no earlier than that; a command is not taken while the previous
// one is still in progress.
// Reset empties the stack; the store contents are not cleared.
module stack_with_remove_by_value #(
  parameter int DEPTH      = swrv_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = swrv_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  swrv_pkg::swrv_in_t  in_item,
  output logic                out_valid,
  output swrv_pkg::swrv_out_t out_item
);
  import swrv_pkg::*;

  swrv_dp_cmd_t  dp_cmd;
  swrv_dp_stat_t dp_stat;

  // sequencer
  swrv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .command   (in_item.command),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // entry store and registers
  swrv_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_item.value),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_item (out_item)
  );

endmodule

>>> hw/rtl/swrv_ctrl.sv
module swrv_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [1:0]              command,
  input  swrv_pkg::swrv_dp_stat_t dp_stat,
  output swrv_pkg::swrv_dp_cmd_t  dp_cmd,
  output logic                    busy,
  output logic                    out_valid
);
  import swrv_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_EXEC     = 9'b000000010,
    S_SRCH_RD  = 9'b000000100,
    S_SRCH_CMP = 9'b000001000,
    S_SHF_RD   = 9'b000010000,
    S_SHF_WR   = 9'b000100000,
    S_TOP_RD   = 9'b001000000,
    S_TOP_CAP  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  // state and command registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_PUSH;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = command;
          dp_cmd.load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.set_status = 1'b1;
        dp_cmd.status     = ST_DONE;
        state_nxt         = S_DONE;
        priority if (cmd_r == CMD_PUSH) begin
          if (dp_stat.full) begin
            dp_cmd.status = ST_FULL;
          end else begin
            dp_cmd.push_wr = 1'b1;
          end
        end else if (cmd_r == CMD_POP) begin
          if (dp_stat.cnt_zero) begin
            dp_cmd.status = ST_NONE;
          end else begin
            dp_cmd.cnt_dec = 1'b1;
            state_nxt      = S_TOP_RD;
          end
        end else if (cmd_r == CMD_REMOVE) begin
          if (dp_stat.cnt_zero) begin
            dp_cmd.status = ST_NONE;
          end else begin
            dp_cmd.set_status   = 1'b0;
            dp_cmd.idx_from_top = 1'b1;
            state_nxt           = S_SRCH_RD;
          end
        end else begin
          // unused code: no operation
        end
      end
      S_SRCH_RD: begin
        dp_cmd.rd_idx = 1'b1;
        state_nxt     = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        priority if (dp_stat.match) begin
          dp_cmd.set_status = 1'b1;
          dp_cmd.status     = ST_DONE;
          state_nxt         = S_SHF_RD;
        end else if (dp_stat.idx_zero) begin
          dp_cmd.set_status = 1'b1;
          dp_cmd.status     = ST_NONE;
          state_nxt         = S_DONE;
        end else begin
          dp_cmd.idx_dec = 1'b1;
          state_nxt      = S_SRCH_RD;
        end
      end
      S_SHF_RD: begin
        if (dp_stat.shift_more) begin
          dp_cmd.rd_idx_next = 1'b1;
          state_nxt          = S_SHF_WR;
        end else begin
          dp_cmd.cnt_dec = 1'b1;
          state_nxt      = S_TOP_RD;
        end
      end
      S_SHF_WR: begin
        dp_cmd.shift_wr = 1'b1;
        dp_cmd.idx_inc  = 1'b1;
        state_nxt       = S_SHF_RD;
      end
      S_TOP_RD: begin
        if (dp_stat.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          dp_cmd.rd_top = 1'b1;
          state_nxt     = S_TOP_CAP;
        end
      end
      S_TOP_CAP: begin
        dp_cmd.top_cap = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

>>> hw/rtl/swrv_dp.sv
module swrv_dp #(
  parameter int DEPTH      = swrv_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = swrv_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [15:0]             in_value,
  input  swrv_pkg::swrv_dp_cmd_t  dp_cmd,
  output swrv_pkg::swrv_dp_stat_t dp_stat,
  output swrv_pkg::swrv_out_t     out_item
);
  import swrv_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [VALUE_BITS-1:0] top_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [1:0]            status_r;

  logic [31:0]           in_ext;
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W-1:0]      idx_ext;
  logic [CNT_W-1:0]      idx_p1;
  logic [IDX_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [31:0]           cnt_out;
  logic [31:0]           top_out;

  assign in_ext  = 32'(in_value);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign idx_ext = CNT_W'(idx_r);
  assign idx_p1  = idx_ext + CNT_W'(1);

  // count register
  always_comb begin
    cnt_nxt = cnt_r;
    if (dp_cmd.push_wr) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (dp_cmd.cnt_dec) begin
      cnt_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // operand, index, top and status registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      val_r <= in_ext[VALUE_BITS-1:0];
    end
    if (dp_cmd.idx_from_top) begin
      idx_r <= cnt_m1[IDX_W-1:0];
    end else if (dp_cmd.idx_dec) begin
      idx_r <= idx_r - IDX_W'(1);
    end else if (dp_cmd.idx_inc) begin
      idx_r <= idx_p1[IDX_W-1:0];
    end
    if (dp_cmd.push_wr) begin
      top_r <= val_r;
    end else if (dp_cmd.top_cap) begin
      top_r <= rd_data_r;
    end
    if (dp_cmd.set_status) begin
      status_r <= dp_cmd.status;
    end
  end

  // read address select
  always_comb begin
    rd_en   = dp_cmd.rd_idx | dp_cmd.rd_idx_next | dp_cmd.rd_top;
    rd_addr = idx_r;
    if (dp_cmd.rd_idx_next) begin
      rd_addr = idx_p1[IDX_W-1:0];
    end else if (dp_cmd.rd_top) begin
      rd_addr = cnt_m1[IDX_W-1:0];
    end
  end

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (dp_cmd.push_wr) begin
      mem[cnt_r[IDX_W-1:0]] <= val_r;
    end else if (dp_cmd.shift_wr) begin
      mem[idx_r] <= rd_data_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // status back to the controller
  assign dp_stat.cnt_zero   = (cnt_r == '0);
  assign dp_stat.full       = (cnt_r == CNT_W'(DEPTH));
  assign dp_stat.match      = (rd_data_r == val_r);
  assign dp_stat.idx_zero   = (idx_r == '0);
  assign dp_stat.shift_more = (idx_p1 < cnt_r);

  // result fields
  assign cnt_out = 32'(cnt_r);
  assign top_out = 32'(top_r);

  assign out_item.status      = status_r;
  assign out_item.entry_count = cnt_out[4:0];
  assign out_item.is_empty    = (cnt_r == '0);
  assign out_item.top_value   = (cnt_r == '0) ? 16'd0 : top_out[15:0];

endmodule

>>> bench/stack_with_remove_by_value_tb.sv
`timescale 1ns / 100ps

module stack_with_remove_by_value_tb;
  import swrv_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int ITEM_COUNT  = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 100;
  // unused command code, a no-op on the block
  localparam logic [1:0] CMD_NOP = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  swrv_in_t  in_item = '0;
  logic      out_valid;
  swrv_out_t out_item;

  // commands waiting to be driven, expected stack results in order
  swrv_in_t  command_q[$];
  swrv_out_t stack_result_q[$];

  // model copy of the stack
  logic [VALUE_BITS-1:0] stack_mem[DEPTH];
  int held_entries = 0;

  int sent_cnt = 0;
  int accept_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int fail_cnt = 0;

  stack_with_remove_by_value dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // apply one command to the model stack and return the expected result
  function automatic swrv_out_t stack_update(swrv_in_t item);
    swrv_out_t res;
    int hit;
    logic [VALUE_BITS-1:0] v;
    v = item.value[VALUE_BITS-1:0];
    res.status = ST_DONE;
    case (item.command)
      CMD_PUSH: begin
        if (held_entries >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_mem[held_entries] = v;
          held_entries++;
        end
      end
      CMD_POP: begin
        if (held_entries == 0) res.status = ST_NONE;
        else held_entries--;
      end
      CMD_REMOVE: begin
        // topmost match wins, entries above it close up
        hit = -1;
        for (int i = held_entries - 1; i >= 0; i--)
          if (hit < 0 && stack_mem[i] == v) hit = i;
        if (hit < 0) begin
          res.status = ST_NONE;
        end else begin
          for (int j = hit; j < held_entries - 1; j++) stack_mem[j] = stack_mem[j + 1];
          held_entries--;
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(held_entries);
    res.is_empty    = (held_entries == 0);
    res.top_value   = (held_entries == 0) ? '0 : 16'(stack_mem[held_entries - 1]);
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_cnt++;
  endtask

  task automatic queue_command(logic [1:0] cmd, logic [15:0] val);
    swrv_in_t item;
    item.command = cmd;
    item.value   = val;
    command_q.push_back(item);
  endtask

  // driver: bursts of transfers with random gaps, changes on falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accept_cnt != sent_cnt) begin
      // hold the current command until it is taken
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (command_q.size() > 0) begin
      start    <= 1'b1;
      in_item  <= command_q.pop_front();
      sent_cnt <= sent_cnt + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, predict on each accepted command, watchdog
  always @(posedge clk) begin
    logic progress;
    swrv_out_t want;
    progress = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        progress = 1'b1;
        if (stack_result_q.size() == 0) begin
          flag_mismatch("result with none expected", 32'(out_item), 32'd0);
        end else begin
          want = stack_result_q.pop_front();
          if (out_item.status !== want.status)
            flag_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.entry_count !== want.entry_count)
            flag_mismatch("entry_count", 32'(out_item.entry_count), 32'(want.entry_count));
          if (out_item.is_empty !== want.is_empty)
            flag_mismatch("is_empty", 32'(out_item.is_empty), 32'(want.is_empty));
          if (out_item.top_value !== want.top_value)
            flag_mismatch("top_value", 32'(out_item.top_value), 32'(want.top_value));
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        stack_result_q.push_back(stack_update(in_item));
        accept_cnt <= accept_cnt + 1;
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[stack_with_remove_by_value] ERROR");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] value_pool[8];
    int made;
    int mode;
    int len;
    int r;
    logic [15:0] v;

    // directed: empty cases, no-op, duplicates, fill to full, deep remove
    queue_command(CMD_POP, 16'h0000);
    queue_command(CMD_REMOVE, 16'h0000);
    queue_command(CMD_NOP, 16'hFFFF);
    queue_command(CMD_PUSH, 16'hFFFF);
    queue_command(CMD_PUSH, 16'h0000);
    queue_command(CMD_PUSH, 16'hFFFF);
    queue_command(CMD_PUSH, 16'h5A5A);
    queue_command(CMD_REMOVE, 16'hFFFF);
    for (int i = 0; i < 13; i++) queue_command(CMD_PUSH, 16'h8000 >> i);
    queue_command(CMD_PUSH, 16'hA5A5);
    queue_command(CMD_REMOVE, 16'h0000);
    queue_command(CMD_REMOVE, 16'h7777);
    queue_command(CMD_POP, 16'hFFFF);

    // random phases biased toward filling, draining or a mix
    made = 0;
    while (made < ITEM_COUNT) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 80);
      foreach (value_pool[k])
        value_pool[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom_range(0, 65535));
      for (int n = 0; n < len; n++) begin
        r = $urandom_range(0, 99);
        v = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                        : value_pool[$urandom_range(0, 7)];
        case (mode)
          0: begin
            if (r < 65) queue_command(CMD_PUSH, v);
            else if (r < 75) queue_command(CMD_POP, v);
            else if (r < 97) queue_command(CMD_REMOVE, v);
            else queue_command(CMD_NOP, v);
          end
          1: begin
            if (r < 25) queue_command(CMD_PUSH, v);
            else if (r < 55) queue_command(CMD_POP, v);
            else if (r < 98) queue_command(CMD_REMOVE, v);
            else queue_command(CMD_NOP, v);
          end
          default: begin
            if (r < 45) queue_command(CMD_PUSH, v);
            else if (r < 65) queue_command(CMD_POP, v);
            else if (r < 97) queue_command(CMD_REMOVE, v);
            else queue_command(CMD_NOP, v);
          end
        endcase
      end
      made += len;
    end

    // wait for every transfer, then every result, then a quiet spell
    while (command_q.size() != 0 || accept_cnt != sent_cnt) @(posedge clk);
    while (stack_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_cnt == 0 && stack_result_q.size() == 0) begin
      $display("[stack_with_remove_by_value] OK");
    end else begin
      $display("[stack_with_remove_by_value] ERROR");
    end
    $finish;
  end

endmodule
